// ----- src/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DATA_W      = 32;
	localparam int MODE_W      = 3;
	localparam int COUNT_OUT_W = 5;
	localparam int DEPTH_DEF   = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_REAR  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_REAR   = 3'd3,
		MODE_READ       = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic [COUNT_OUT_W-1:0]   entry_count;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	// per-chain command, broadcast to every cell
	typedef struct packed {
		logic shift_in;   // move toward higher index, din enters cell 0
		logic shift_out;  // move toward lower index, cell 0 drops
		logic load;       // write din at the cell whose index equals count
	} cell_cmd_t;

endpackage

// ----- src/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-depth double-ended queue of signed 32-bit values built from two
// chains of shift cells.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high (busy is held low), one
// per cycle. Its response appears on rsp, marked by done, in the next cycle
// and for that one cycle only; it must be captured then. Two copies of
// the contents are kept in rows of cells, one with the front in cell 0 and
// one with the rear in cell 0, so both ends are read from fixed cells and
// every request finishes with the cell update.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  deq_pkg::req_t req,
	output logic          done,
	output deq_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  count_d;
	deq_pkg::status_t                  status_q;
	deq_pkg::status_t                  status_d;
	logic                              done_q;
	logic                              accept;
	logic                              full;
	logic                              empty;
	deq_pkg::cell_cmd_t                front_cmd;
	deq_pkg::cell_cmd_t                rear_cmd;
	logic signed [deq_pkg::DATA_W-1:0] front_head;
	logic signed [deq_pkg::DATA_W-1:0] rear_head;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		front_cmd = '0;
		rear_cmd  = '0;
		status_d  = deq_pkg::ST_OK;
		count_d   = count_q;
		case (req.mode)
			deq_pkg::MODE_PUSH_FRONT: begin
				if (full) begin
					status_d = deq_pkg::ST_OVERFLOW;
				end else begin
					front_cmd.shift_in = accept;
					rear_cmd.load      = accept;
					count_d            = count_q + CNT_W'(1);
				end
			end
			deq_pkg::MODE_PUSH_REAR: begin
				if (full) begin
					status_d = deq_pkg::ST_OVERFLOW;
				end else begin
					rear_cmd.shift_in = accept;
					front_cmd.load    = accept;
					count_d           = count_q + CNT_W'(1);
				end
			end
			deq_pkg::MODE_POP_FRONT: begin
				if (empty) begin
					status_d = deq_pkg::ST_UNDERFLOW;
				end else begin
					front_cmd.shift_out = accept;
					count_d             = count_q - CNT_W'(1);
				end
			end
			deq_pkg::MODE_POP_REAR: begin
				if (empty) begin
					status_d = deq_pkg::ST_UNDERFLOW;
				end else begin
					rear_cmd.shift_out = accept;
					count_d            = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = deq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= deq_pkg::ST_OK;
			done_q   <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q  <= count_d;
				status_q <= status_d;
			end
		end
	end

	deq_chain #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_front_chain (
		.clk   (clk),
		.cmd   (front_cmd),
		.count (count_q),
		.din   (req.data_in),
		.head  (front_head)
	);

	deq_chain #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_rear_chain (
		.clk   (clk),
		.cmd   (rear_cmd),
		.count (count_q),
		.din   (req.data_in),
		.head  (rear_head)
	);

	assign done             = done_q;
	assign rsp.status       = status_q;
	assign rsp.front_value  = empty ? '1 : front_head;
	assign rsp.rear_value   = empty ? '1 : rear_head;
	assign rsp.entry_count  = deq_pkg::COUNT_OUT_W'(count_q);
	assign rsp.is_empty     = empty;
	assign rsp.is_full      = full;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("response strobe missing after request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && empty && (req.mode == deq_pkg::MODE_POP_FRONT ||
			req.mode == deq_pkg::MODE_POP_REAR))
		|=> (rsp.status == deq_pkg::ST_UNDERFLOW) && (count_q == '0))
		else $error("pop on empty queue not flagged");

	a_push_front: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !full && req.mode == deq_pkg::MODE_PUSH_FRONT)
		|=> rsp.front_value == $past(req.data_in))
		else $error("front value does not match pushed value");

endmodule

// ----- src/deq_cell.sv -----
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of a shift chain: holds, shifts from either neighbor,
// or loads the pushed value when its index matches the entry count.
// ----------------------------------------------------------------------------
module deq_cell #(
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic                               clk,
	input  deq_pkg::cell_cmd_t                 cmd,
	input  logic [CNT_W-1:0]                   count,
	input  logic signed [deq_pkg::DATA_W-1:0]  din,
	input  logic signed [deq_pkg::DATA_W-1:0]  left_d,
	input  logic signed [deq_pkg::DATA_W-1:0]  right_d,
	output logic signed [deq_pkg::DATA_W-1:0]  q
);

	logic signed [deq_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (cmd.shift_in) begin
			data_q <= left_d;
		end else if (cmd.shift_out) begin
			data_q <= right_d;
		end else if (cmd.load && (count == CNT_W'(INDEX))) begin
			data_q <= din;
		end
	end

	assign q = data_q;

endmodule

// ----- src/deq_chain.sv -----
// ----------------------------------------------------------------------------
// deq_chain
// Row of DEPTH cells; cell 0 holds the end of the queue this chain faces.
// ----------------------------------------------------------------------------
module deq_chain #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  deq_pkg::cell_cmd_t                 cmd,
	input  logic [CNT_W-1:0]                   count,
	input  logic signed [deq_pkg::DATA_W-1:0]  din,
	output logic signed [deq_pkg::DATA_W-1:0]  head
);

	logic signed [deq_pkg::DATA_W-1:0] cell_q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [deq_pkg::DATA_W-1:0] left_d;
		logic signed [deq_pkg::DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = din;
		end else begin : g_mid
			assign left_d = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_q[i];
		end else begin : g_inner
			assign right_d = cell_q[i+1];
		end

		deq_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.count   (count),
			.din     (din),
			.left_d  (left_d),
			.right_d (right_d),
			.q       (cell_q[i])
		);
	end

	assign head = cell_q[0];

endmodule
